// ===== design/ggbs_pkg.sv =====
`timescale 1ns / 1ps
package ggbs_pkg;

	localparam int ADDR_W = 20;
	localparam int VALUE_W = 16;
	localparam int LON_W = 32;
	localparam int LAT_W = 32;
	localparam int HEIGHT_W = 32;

	localparam int GRID_ROWS_DEF = 721;
	localparam int GRID_COLUMNS_DEF = 1440;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int CMD_DEPTH = 8;
	localparam int RES_DEPTH = 8;

	// latitude limit, a quarter turn
	localparam logic signed [LAT_W-1:0] LAT_LIM = 32'sh4000_0000;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// per-item control carried from the front end to the back end
	typedef struct packed {
		logic sample;
		logic we;
		logic dup;
		logic r0;
		logic c0;
		logic last;
	} ctl_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int bank_row_w(input int rows);
		return idx_w((rows + 1) >> 1);
	endfunction

	function automatic int bank_col_w(input int cols);
		return idx_w((cols + 1) >> 1);
	endfunction

	function automatic int bank_addr_w(input int rows, input int cols);
		return idx_w(((rows + 1) >> 1) * ((cols + 1) >> 1));
	endfunction

endpackage

// ===== design/ggbs_if.sv =====
`timescale 1ns / 1ps
interface ggbs_req_if import ggbs_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic [ADDR_W-1:0] load_address;
	logic signed [VALUE_W-1:0] load_value;
	logic [LON_W-1:0] longitude;
	logic signed [LAT_W-1:0] latitude;

	modport source (output valid, op, load_address, load_value, longitude, latitude,
		input ready);
	modport sink (input valid, op, load_address, load_value, longitude, latitude,
		output ready);
endinterface

interface ggbs_rsp_if import ggbs_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [HEIGHT_W-1:0] height;

	modport source (output valid, height, input ready);
	modport sink (input valid, height, output ready);
endinterface

// ===== design/ggbs_ram.sv =====
`timescale 1ns / 1ps
module ggbs_ram import ggbs_pkg::*; #(
	parameter int WIDTH = VALUE_W,
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [idx_w(DEPTH)-1:0]   addr,
	input  logic [WIDTH-1:0]          wdata,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/ggbs_fifo.sv =====
`timescale 1ns / 1ps
module ggbs_fifo import ggbs_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);
	localparam int PW = idx_w(DEPTH);
	localparam int CW = idx_w(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	assign dout = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
endmodule

// ===== design/ggbs_front.sv =====
`timescale 1ns / 1ps
module ggbs_front import ggbs_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ggbs_req_if.sink req,
	input  logic pop,
	output logic cmd_valid,
	output ctl_t ctl,
	output logic [bank_addr_w(GRID_ROWS, GRID_COLUMNS)-1:0] row_base_e,
	output logic [bank_addr_w(GRID_ROWS, GRID_COLUMNS)-1:0] row_base_o,
	output logic [bank_col_w(GRID_COLUMNS)-1:0] col_idx_e,
	output logic [bank_col_w(GRID_COLUMNS)-1:0] col_idx_o,
	output logic [FRACTION_BITS-1:0] weight_x,
	output logic [FRACTION_BITS-1:0] weight_y,
	output logic signed [VALUE_W-1:0] value
);
	localparam int FB = FRACTION_BITS;
	localparam int RNW = idx_w(GRID_ROWS);
	localparam int CNW = idx_w(GRID_COLUMNS + 1);
	localparam int RIW = bank_row_w(GRID_ROWS);
	localparam int CIW = bank_col_w(GRID_COLUMNS);
	localparam int AWB = bank_addr_w(GRID_ROWS, GRID_COLUMNS);
	localparam int CB = (GRID_COLUMNS + 1) / 2;
	localparam bit ODD = (GRID_COLUMNS % 2) == 1;
	localparam int HPW = CNW + LON_W;
	localparam int VPW = RNW + LAT_W;
	localparam int DW = LAT_W + 1;
	// reciprocal of the column count for splitting a load address
	localparam int LG = idx_w(GRID_COLUMNS);
	localparam int K = ADDR_W + LG;
	localparam longint RECIP = ((longint'(1) << K) + GRID_COLUMNS - 1) / GRID_COLUMNS;
	localparam int MW = ADDR_W + 2;
	localparam int QMW = ADDR_W + MW;
	localparam longint GRID_WORDS = longint'(GRID_ROWS) * GRID_COLUMNS;
	localparam int FCW = idx_w(CMD_DEPTH + 1);

	logic [FCW-1:0] fcnt_q;
	logic accept;

	// stage 1: products
	logic signed [LAT_W-1:0] lat_c;
	logic signed [DW-1:0] down_w;
	logic [HPW-1:0] hpos_d, hpos_s1;
	logic [VPW-1:0] vpos_d, vpos_s1;
	logic [QMW-1:0] qm_d, qm_s1;
	logic v_s1, smp_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic signed [VALUE_W-1:0] value_s1;

	// stage 2: cell decode, load address split
	logic [RNW:0] row_raw;
	logic [RNW-1:0] row_d, row_s2;
	logic [CNW-1:0] col_s2;
	logic [FB-1:0] xf_s2, yf_s2;
	logic [ADDR_W-1:0] q_d, q_s2, qc_s2, addr_s2;
	logic ok_s2, v_s2, smp_s2;
	logic signed [VALUE_W-1:0] value_s2;

	// stage 3: bank indices
	logic [RNW-1:0] r, r2, re_full, ro_full;
	logic [CNW-1:0] c, c2, ce_full, co_full;
	ctl_t ctl_d, ctl_s3;
	logic [RIW-1:0] ridx_e_s3, ridx_o_s3;
	logic [CIW-1:0] cidx_e_d, cidx_o_d, cidx_e_s3, cidx_o_s3;
	logic [FB-1:0] xf_s3, yf_s3;
	logic v_s3;
	logic signed [VALUE_W-1:0] value_s3;

	// stage 4: row bases
	logic v_s4;
	ctl_t ctl_s4;
	logic [AWB-1:0] pe_s4, po_s4;
	logic [CIW-1:0] ce_s4, co_s4;
	logic [FB-1:0] xf_s4, yf_s4;
	logic signed [VALUE_W-1:0] value_s4;

	assign accept = req.valid && req.ready;
	assign req.ready = (fcnt_q < FCW'(CMD_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (accept && !pop) begin
			fcnt_q <= FCW'(fcnt_q + 1'b1);
		end else if (pop && !accept) begin
			fcnt_q <= FCW'(fcnt_q - 1'b1);
		end
	end

	always_comb begin
		lat_c = req.latitude;
		if (req.latitude > LAT_LIM) begin
			lat_c = LAT_LIM;
		end else if (req.latitude < -LAT_LIM) begin
			lat_c = -LAT_LIM;
		end
		down_w = DW'(LAT_LIM) - DW'(lat_c);
		hpos_d = HPW'(GRID_COLUMNS) * HPW'(req.longitude);
		vpos_d = VPW'(GRID_ROWS - 1) * VPW'(down_w[LAT_W-1:0]);
		qm_d = QMW'(req.load_address) * QMW'(RECIP);
	end

	always_comb begin
		row_raw = vpos_s1[VPW-1:LAT_W-1];
		row_d = (row_raw > (RNW+1)'(GRID_ROWS - 1)) ? RNW'(GRID_ROWS - 1) : RNW'(row_raw);
		q_d = ADDR_W'(qm_s1 >> K);
	end

	always_comb begin
		r = smp_s2 ? row_s2 : RNW'(q_s2);
		c = smp_s2 ? col_s2 : CNW'(addr_s2 - qc_s2);
		ctl_d.sample = smp_s2;
		ctl_d.last = (r == RNW'(GRID_ROWS - 1));
		ctl_d.r0 = r[0];
		ctl_d.c0 = c[0];
		ctl_d.we = !smp_s2 && ok_s2;
		ctl_d.dup = !smp_s2 && ODD && (c == '0);
		r2 = ctl_d.last ? r : RNW'(r + 1'b1);
		if (c == CNW'(GRID_COLUMNS - 1)) begin
			// east of the last column wraps; odd widths keep a copy of column 0
			c2 = ODD ? CNW'(GRID_COLUMNS) : '0;
		end else begin
			c2 = CNW'(c + 1'b1);
		end
		re_full = r[0] ? r2 : r;
		ro_full = r[0] ? r : r2;
		ce_full = c[0] ? c2 : c;
		co_full = c[0] ? c : c2;
		cidx_e_d = CIW'(ce_full >> 1);
		cidx_o_d = ctl_d.dup ? CIW'(CB - 1) : CIW'(co_full >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= (req.op == OP_SAMPLE);
		addr_s1 <= req.load_address;
		value_s1 <= req.load_value;
		hpos_s1 <= hpos_d;
		vpos_s1 <= vpos_d;
		qm_s1 <= qm_d;

		smp_s2 <= smp_s1;
		row_s2 <= row_d;
		col_s2 <= hpos_s1[HPW-1:LON_W];
		xf_s2 <= hpos_s1[LON_W-1 -: FB];
		yf_s2 <= vpos_s1[LAT_W-2 -: FB];
		q_s2 <= q_d;
		qc_s2 <= ADDR_W'(q_d * ADDR_W'(GRID_COLUMNS));
		addr_s2 <= addr_s1;
		ok_s2 <= (longint'(addr_s1) < GRID_WORDS);
		value_s2 <= value_s1;

		ctl_s3 <= ctl_d;
		ridx_e_s3 <= RIW'(re_full >> 1);
		ridx_o_s3 <= RIW'(ro_full >> 1);
		cidx_e_s3 <= cidx_e_d;
		cidx_o_s3 <= cidx_o_d;
		xf_s3 <= xf_s2;
		yf_s3 <= yf_s2;
		value_s3 <= value_s2;

		ctl_s4 <= ctl_s3;
		pe_s4 <= AWB'(ridx_e_s3) * AWB'(CB);
		po_s4 <= AWB'(ridx_o_s3) * AWB'(CB);
		ce_s4 <= cidx_e_s3;
		co_s4 <= cidx_o_s3;
		xf_s4 <= xf_s3;
		yf_s4 <= yf_s3;
		value_s4 <= value_s3;
	end

	assign cmd_valid = v_s4;
	assign ctl = ctl_s4;
	assign row_base_e = pe_s4;
	assign row_base_o = po_s4;
	assign col_idx_e = ce_s4;
	assign col_idx_o = co_s4;
	assign weight_x = xf_s4;
	assign weight_y = yf_s4;
	assign value = value_s4;
endmodule

// ===== design/ggbs_back.sv =====
`timescale 1ns / 1ps
module ggbs_back import ggbs_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  ctl_t ctl,
	input  logic [bank_addr_w(GRID_ROWS, GRID_COLUMNS)-1:0] row_base_e,
	input  logic [bank_addr_w(GRID_ROWS, GRID_COLUMNS)-1:0] row_base_o,
	input  logic [bank_col_w(GRID_COLUMNS)-1:0] col_idx_e,
	input  logic [bank_col_w(GRID_COLUMNS)-1:0] col_idx_o,
	input  logic [FRACTION_BITS-1:0] weight_x,
	input  logic [FRACTION_BITS-1:0] weight_y,
	input  logic signed [VALUE_W-1:0] value,
	output logic cmd_pop,
	ggbs_rsp_if.source rsp
);
	localparam int FB = FRACTION_BITS;
	localparam int AWB = bank_addr_w(GRID_ROWS, GRID_COLUMNS);
	localparam int BANK_DEPTH = ((GRID_ROWS + 1) / 2) * ((GRID_COLUMNS + 1) / 2);
	localparam int TW = FB + 18;
	localparam int ACW = TW + FB + 2;
	localparam int SH = 2 * FB - 16;
	localparam int RCW = idx_w(RES_DEPTH + 1);

	logic [RCW-1:0] rcnt_q;
	logic smp_pop, res_push, res_full, res_empty, res_pop;
	logic [HEIGHT_W-1:0] res_din, res_dout;

	logic [VALUE_W-1:0] rd [4];

	logic v_s1, r0_s1, c0_s1, last_s1;
	logic [FB-1:0] xf_s1, yf_s1, yf_s2;
	logic signed [VALUE_W-1:0] a1, a2, b1, b2, b1x, b2x;
	logic signed [VALUE_W:0] da, db;
	logic signed [TW-1:0] top_d, bot_d, top_s2, bot_s2;
	logic v_s2, v_s3;
	logic signed [TW:0] dv;
	logic signed [ACW-1:0] acc_d, acc_s3;

	assign cmd_pop = cmd_valid && (!ctl.sample || (rcnt_q < RCW'(RES_DEPTH)));
	assign smp_pop = cmd_pop && ctl.sample;

	for (genvar gi = 0; gi < 4; gi++) begin : g_bank
		localparam logic RBIT = 1'(gi >> 1);
		localparam logic CBIT = 1'(gi & 1);
		logic bank_we;
		logic [AWB-1:0] bank_addr;

		assign bank_we = cmd_pop && ctl.we && (ctl.r0 == RBIT) &&
			((ctl.c0 == CBIT) || (ctl.dup && CBIT));
		assign bank_addr = (RBIT ? row_base_o : row_base_e) +
			AWB'(CBIT ? col_idx_o : col_idx_e);

		ggbs_ram #(
			.WIDTH(VALUE_W),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk(clk),
			.we(bank_we),
			.addr(bank_addr),
			.wdata(value),
			.rdata(rd[gi])
		);
	end

	always_comb begin
		a1 = r0_s1 ? (c0_s1 ? rd[3] : rd[2]) : (c0_s1 ? rd[1] : rd[0]);
		a2 = r0_s1 ? (c0_s1 ? rd[2] : rd[3]) : (c0_s1 ? rd[0] : rd[1]);
		b1x = r0_s1 ? (c0_s1 ? rd[1] : rd[0]) : (c0_s1 ? rd[3] : rd[2]);
		b2x = r0_s1 ? (c0_s1 ? rd[0] : rd[1]) : (c0_s1 ? rd[2] : rd[3]);
		// last row has no southern neighbor
		b1 = last_s1 ? a1 : b1x;
		b2 = last_s1 ? a2 : b2x;
		da = (VALUE_W+1)'(a2) - (VALUE_W+1)'(a1);
		db = (VALUE_W+1)'(b2) - (VALUE_W+1)'(b1);
		top_d = (TW'(a1) <<< FB) + TW'(da) * TW'($signed({1'b0, xf_s1}));
		bot_d = (TW'(b1) <<< FB) + TW'(db) * TW'($signed({1'b0, xf_s1}));
		dv = (TW+1)'(bot_s2) - (TW+1)'(top_s2);
		acc_d = (ACW'(top_s2) <<< FB) + ACW'(dv) * ACW'($signed({1'b0, yf_s2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rcnt_q <= '0;
		end else begin
			v_s1 <= smp_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (smp_pop && !res_pop) begin
				rcnt_q <= RCW'(rcnt_q + 1'b1);
			end else if (res_pop && !smp_pop) begin
				rcnt_q <= RCW'(rcnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		r0_s1 <= ctl.r0;
		c0_s1 <= ctl.c0;
		last_s1 <= ctl.last;
		xf_s1 <= weight_x;
		yf_s1 <= weight_y;
		top_s2 <= top_d;
		bot_s2 <= bot_d;
		yf_s2 <= yf_s1;
		acc_s3 <= acc_d;
	end

	// arithmetic shift floors toward minus infinity
	assign res_din = HEIGHT_W'(acc_s3 >>> SH);
	assign res_push = v_s3;
	assign res_pop = rsp.valid && rsp.ready;

	ggbs_fifo #(
		.WIDTH(HEIGHT_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din(res_din),
		.pop(res_pop),
		.dout(res_dout),
		.empty(res_empty),
		.full(res_full)
	);

	assign rsp.valid = !res_empty;
	assign rsp.height = res_dout;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result fifo overflow");

	a_res_credit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rcnt_q != '0))
		else $error("result without credit");
endmodule

// ===== design/geoid_grid_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// req      in   valid/ready    op, load_address, load_value, longitude, latitude
// rsp      out  valid/ready    height (one per sample request, none per load)
//
// one request per cycle sustained while the command queue has credit (req.ready high)
// a sample passes through the front end (4 stages), the command queue and the back end
// (bank read, two interpolation stages) before the result fifo
// reset clears only control; grid banks are not cleared, words read undefined until loaded
// either side may stall: the command queue and the result fifo take up the slack,
// and req.ready drops only when the command queue has no credit left
module geoid_grid_bilinear_sampler import ggbs_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ggbs_req_if.sink req,
	ggbs_rsp_if.source rsp
);
	localparam int FB = FRACTION_BITS;
	localparam int AWB = bank_addr_w(GRID_ROWS, GRID_COLUMNS);
	localparam int CIW = bank_col_w(GRID_COLUMNS);
	localparam int QW = $bits(ctl_t) + 2 * AWB + 2 * CIW + 2 * FB + VALUE_W;

	// front end output
	logic f_valid;
	ctl_t f_ctl;
	logic [AWB-1:0] f_pe, f_po;
	logic [CIW-1:0] f_ce, f_co;
	logic [FB-1:0] f_xf, f_yf;
	logic signed [VALUE_W-1:0] f_value;

	// queue head
	ctl_t q_ctl;
	logic [AWB-1:0] q_pe, q_po;
	logic [CIW-1:0] q_ce, q_co;
	logic [FB-1:0] q_xf, q_yf;
	logic signed [VALUE_W-1:0] q_value;

	logic [QW-1:0] cmd_din, cmd_dout;
	logic cmd_empty, cmd_full, cmd_pop;

	// front: split loads into bank words, locate the cell for samples
	ggbs_front #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLUMNS(GRID_COLUMNS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.pop(cmd_pop),
		.cmd_valid(f_valid),
		.ctl(f_ctl),
		.row_base_e(f_pe),
		.row_base_o(f_po),
		.col_idx_e(f_ce),
		.col_idx_o(f_co),
		.weight_x(f_xf),
		.weight_y(f_yf),
		.value(f_value)
	);

	assign cmd_din = {f_ctl, f_pe, f_po, f_ce, f_co, f_xf, f_yf, f_value};

	// decouples front and back; front credit keeps it from overflowing
	ggbs_fifo #(
		.WIDTH(QW),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.din(cmd_din),
		.pop(cmd_pop),
		.dout(cmd_dout),
		.empty(cmd_empty),
		.full(cmd_full)
	);

	assign {q_ctl, q_pe, q_po, q_ce, q_co, q_xf, q_yf, q_value} = cmd_dout;

	// back: four parity banks give all corners in one read, then interpolate
	ggbs_back #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLUMNS(GRID_COLUMNS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!cmd_empty),
		.ctl(q_ctl),
		.row_base_e(q_pe),
		.row_base_o(q_po),
		.col_idx_e(q_ce),
		.col_idx_o(q_co),
		.weight_x(q_xf),
		.weight_y(q_yf),
		.value(q_value),
		.cmd_pop(cmd_pop),
		.rsp(rsp)
	);

	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> !cmd_full)
		else $error("command queue overflow");

	a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("pop from empty command queue");
endmodule
